/* hdl/sorted_table_binary_search_top_defines.svh */
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top_defines
// Assertion macros shared by the checker of the binary search block.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define STBS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define STBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/stbs_pkg.sv */
// ----------------------------------------------------------------------------
// stbs_pkg
// Widths, codes and controller/datapath signal groups of the search block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stbs_pkg;

    localparam int IDX_W           = 10;
    localparam int DATA_W          = 32;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;
    localparam int DEF_TABLE_DEPTH = 1024;

    localparam logic [IDX_W-1:0] RANGE_FIRST_RST = 10'd0;
    localparam logic [IDX_W-1:0] RANGE_LAST_RST  = 10'd1023;

    // Item opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Register select, taken from paddr[2]
    localparam logic REG_RANGE_FIRST = 1'b0;
    localparam logic REG_RANGE_LAST  = 1'b1;

    typedef struct packed {
        logic wr_en;    // store the input item in the table
        logic start;    // load key and bounds of a search
        logic probe;    // register midpoint and read the table there
        logic compare;  // narrow the range or record the hit
        logic publish;  // move the result into the output register
    } stbs_cmd_t;

    typedef struct packed {
        logic range_empty;  // configured range holds no entry
        logic hit;          // probed entry equals the key
        logic miss;         // range runs empty after this probe
        logic out_free;     // output register can take a result
    } stbs_sts_t;

endpackage

/* hdl/stbs_ifs.sv */
// ----------------------------------------------------------------------------
// stbs_ifs
// Request and response channels of the search block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stbs_req_if import stbs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output op, output index, output value, input ready);
    modport sink (input valid, input op, input index, input value, output ready);
endinterface

interface stbs_rsp_if import stbs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] position;

    modport source (output valid, output found, output position, input ready);
    modport sink (input valid, input found, input position, output ready);
endinterface

/* hdl/stbs_ctrl.sv */
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer: accepts items, steps the probe loop, hands off the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stbs_ctrl import stbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_op,
    output logic      req_ready,
    input  stbs_sts_t sts,
    output stbs_cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_op == OP_SEARCH)
                    begin
                        cmd.start  = 1'b1;
                        state_next = sts.range_empty ? S_DONE : S_PROBE;
                    end
                    else
                    begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            S_PROBE:
            begin
                cmd.probe  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = (sts.hit || sts.miss) ? S_DONE : S_PROBE;
            end
            S_DONE:
            begin
                // hold until the output register drains
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/stbs_datapath.sv */
// ----------------------------------------------------------------------------
// stbs_datapath
// Table memory, search bounds, probe compare and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stbs_datapath import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [IDX_W-1:0]         in_index,
    input  logic signed [DATA_W-1:0] in_value,
    input  logic [IDX_W-1:0]         range_first,
    input  logic [IDX_W-1:0]         range_last,
    input  stbs_cmd_t                cmd,
    output stbs_sts_t                sts,
    input  logic                     rsp_ready,
    output logic                     rsp_valid,
    output logic                     rsp_found,
    output logic [IDX_W-1:0]         rsp_position
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CW     = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] LAST_C  = CW'(TABLE_DEPTH - 1);

    logic signed [DATA_W-1:0] mem [TABLE_DEPTH];

    logic signed [DATA_W-1:0] rd_data_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic [ADDR_W-1:0]        lo_reg;
    logic [ADDR_W-1:0]        hi_reg;
    logic [ADDR_W-1:0]        mid_reg;
    logic                     res_found_reg;
    logic [IDX_W-1:0]         res_pos_reg;
    logic                     rsp_valid_reg;
    logic                     rsp_found_reg;
    logic [IDX_W-1:0]         rsp_position_reg;

    logic [CW-1:0]     first_ext;
    logic [CW-1:0]     last_ext;
    logic [CW-1:0]     last_sat;
    logic [CW-1:0]     wr_ext;
    logic [CW-1:0]     mid_ext;
    logic              wr_ok;
    logic [ADDR_W:0]   mid_sum;
    logic [ADDR_W-1:0] mid_calc;
    logic              hit;
    logic              gt;

    // Clamp the upper bound to the table
    assign first_ext = CW'(range_first);
    assign last_ext  = CW'(range_last);
    assign last_sat  = (last_ext > LAST_C) ? LAST_C : last_ext;
    assign wr_ext    = CW'(in_index);
    assign wr_ok     = (wr_ext < DEPTH_C);

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc = mid_sum[ADDR_W:1];
    assign mid_ext  = CW'(mid_reg);

    assign hit = (rd_data_reg == key_reg);
    assign gt  = (rd_data_reg > key_reg);

    assign sts.range_empty = (first_ext > last_sat);
    assign sts.hit         = hit;
    // Drop out when the half to keep is empty
    assign sts.miss        = !hit && (gt ? (mid_reg == lo_reg) : (mid_reg == hi_reg));
    assign sts.out_free    = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_ok)
        begin
            mem[wr_ext[ADDR_W-1:0]] <= in_value;
        end
        if (cmd.probe)
        begin
            rd_data_reg <= mem[mid_calc];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg       <= in_value;
            lo_reg        <= first_ext[ADDR_W-1:0];
            hi_reg        <= last_sat[ADDR_W-1:0];
            res_found_reg <= 1'b0;
            res_pos_reg   <= '0;
        end
        if (cmd.probe)
        begin
            mid_reg <= mid_calc;
        end
        if (cmd.compare)
        begin
            if (hit)
            begin
                res_found_reg <= 1'b1;
                res_pos_reg   <= mid_ext[IDX_W-1:0];
            end
            else if (gt)
            begin
                hi_reg <= mid_reg - ADDR_W'(1);
            end
            else
            begin
                lo_reg <= mid_reg + ADDR_W'(1);
            end
        end
        if (cmd.publish)
        begin
            rsp_found_reg    <= res_found_reg;
            rsp_position_reg <= res_pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign rsp_found    = rsp_found_reg;
    assign rsp_position = rsp_position_reg;

endmodule

/* hdl/sorted_table_binary_search_top.sv */
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Table of signed entries with binary search over a configured index range.
// ----------------------------------------------------------------------------
//   channel  | dir | transfer carries
//   ---------+-----+-------------------------------------------
//   req      | in  | op, index, value (write entry or search key)
//   rsp      | out | found, position (one per search)
//   apb      | in  | range_first at 0x0, range_last at 0x4
//
// A write transfer leaves the block ready for the next transfer. A search
// makes P probes (at most floor(log2) of the range size plus one, 11 for
// 1024 entries): each probe reads the table into a register in the probe
// state and compares it in the compare state. An empty range skips the probes.
// rst_n resets the controller, the output valid and the range registers;
// the table holds garbage until written. A stalled result waits in the
// output register while the next write or search is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_table_binary_search_top import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    stbs_req_if.sink           req,
    stbs_rsp_if.source         rsp
);

    logic [IDX_W-1:0] range_first_reg;
    logic [IDX_W-1:0] range_last_reg;
    logic             cfg_wr;
    stbs_cmd_t        cmd;
    stbs_sts_t        sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_first_reg <= RANGE_FIRST_RST;
            range_last_reg  <= RANGE_LAST_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_RANGE_FIRST: range_first_reg <= pwdata[IDX_W-1:0];
                REG_RANGE_LAST:  range_last_reg  <= pwdata[IDX_W-1:0];
                default:         range_first_reg <= range_first_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_RANGE_FIRST: prdata = PDATA_W'(range_first_reg);
            REG_RANGE_LAST:  prdata = PDATA_W'(range_last_reg);
            default:         prdata = '0;
        endcase
    end

    stbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_index     (req.index),
        .in_value     (req.value),
        .range_first  (range_first_reg),
        .range_last   (range_last_reg),
        .cmd          (cmd),
        .sts          (sts),
        .rsp_ready    (rsp.ready),
        .rsp_valid    (rsp.valid),
        .rsp_found    (rsp.found),
        .rsp_position (rsp.position)
    );

endmodule

/* hdl/stbs_checker.sv */
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks of the search block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_table_binary_search_top_defines.svh"

module stbs_checker import stbs_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             req_op,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic             rsp_found,
    input logic [IDX_W-1:0] rsp_position
);

    // Stalled result holds
    `STBS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_position), "stalled result changed")

    // A miss reports position zero
    `STBS_ASSERT_SAME(a_miss_pos, rsp_valid && !rsp_found, rsp_position == '0, "miss with nonzero position")

    // A search keeps the block busy in the next cycle
    `STBS_ASSERT_NEXT(a_search_busy, req_valid && req_ready && req_op == OP_SEARCH, !req_ready, "ready stayed high after search transfer")

    // Only a search transfer takes ready down
    `STBS_ASSERT_SAME(a_busy_cause, $fell(req_ready), $past(req_valid && req_op == OP_SEARCH), "ready fell without a search transfer")

endmodule

bind sorted_table_binary_search_top stbs_checker u_stbs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_op       (req.op),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_found    (rsp.found),
    .rsp_position (rsp.position)
);
